// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define SMEU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Next-cycle implication, sampled on the rising clock, off during reset
`define SMEU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

// ===== hw/rtl/smeu_pkg.sv =====
// ----------------------------------------------------------------------------
// smeu_pkg
// Sizes, opcodes and status codes of the stack machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smeu_pkg;

   // Word and storage sizes
   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int STACK_DEPTH = 64;
   localparam int VAR_COUNT   = 64;
   localparam int LABEL_COUNT = 256;
   localparam int LABEL_W     = 8;
   localparam int ACTION_W    = 4;
   localparam int VAR_IDX_W   = 6;
   localparam int STATUS_W    = 3;

   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);
   localparam int VAR_AW  = $clog2(VAR_COUNT);

   // Shared add/subtract unit and iteration counts
   localparam int ALU_W     = DATA_W + 2;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int MUL_STEPS = DATA_W;
   localparam int DIV_STEPS = DATA_W + FRAC_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [ACTION_W-1:0] {
      OP_DATA  = 4'd0,
      OP_ADD   = 4'd1,
      OP_DIV   = 4'd2,
      OP_MUL   = 4'd3,
      OP_SUB   = 4'd4,
      OP_LOAD  = 4'd5,
      OP_STORE = 4'd6,
      OP_DUP   = 4'd7,
      OP_PUSH  = 4'd8,
      OP_SWAP  = 4'd9,
      OP_JNE   = 4'd10,
      OP_JG    = 4'd11,
      OP_JMP   = 4'd12,
      OP_PRINT = 4'd13,
      OP_LABEL = 4'd14
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_UNDER = 3'd1,
      ST_OVER  = 3'd2,
      ST_DIVZ  = 3'd3,
      ST_SAT   = 3'd4
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack-machine instruction per request word against an
// operand stack and a variable store, one response word per request.
// ----------------------------------------------------------------------------
// A request word is taken only while the unit is idle, and the stack and
// store are read at the accepting edge. Stack, store, branch and print
// instructions pass through an execute state, a response state that loads
// the response register and the idle state in which the next word is taken.
// Swap adds a state for its second stack write. Multiply runs one shift-add
// step of the shared adder per cycle over 32 steps, then a fix-up state
// signs and saturates; divide runs one restoring subtract step per cycle
// over 48 quotient bits, then the same fix-up state. A finished word waits
// in the response register while the next request is accepted; the unit
// holds in its response state only if that register is still full.
// The variable store reads as zero until a slot is written; no clearing pass.
`default_nettype none

module stack_machine_execute_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [smeu_pkg::ACTION_W-1:0]      req_action,
   input  wire logic [smeu_pkg::VAR_IDX_W-1:0]     req_var_index,
   input  wire logic signed [smeu_pkg::DATA_W-1:0] req_immediate,
   input  wire logic [smeu_pkg::LABEL_W-1:0]       req_label_id,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_branch_taken,
   output logic [smeu_pkg::LABEL_W-1:0]            rsp_branch_label,
   output logic                                    rsp_print_valid,
   output logic signed [smeu_pkg::DATA_W-1:0]      rsp_print_value,
   output logic [smeu_pkg::STATUS_W-1:0]           rsp_status
);

   localparam int DW = smeu_pkg::DATA_W;
   localparam int AW = smeu_pkg::ALU_W;
   localparam int PW = smeu_pkg::PROD_W;
   localparam int QW = smeu_pkg::DIV_STEPS;
   localparam int FRAC_POS = smeu_pkg::FRAC_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_MUL,
      S_DIV,
      S_FIX,
      S_SWAP,
      S_RESP
   } state_type;

   // Sequencer and instruction registers
   state_type                       state_ff, state_in;
   logic [smeu_pkg::SP_W-1:0]       sp_ff, sp_in;
   smeu_pkg::op_type                op_ff, op_in;
   logic [smeu_pkg::VAR_AW-1:0]     slot_ff, slot_in;
   logic [DW-1:0]                   imm_ff, imm_in;
   logic [smeu_pkg::LABEL_W-1:0]    label_ff, label_in;
   logic [smeu_pkg::CNT_W-1:0]      cnt_ff, cnt_in;

   // Iteration registers of the shared unit
   logic [PW-1:0]                   prod_ff, prod_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [QW-1:0]                   dvd_ff, dvd_in;
   logic [DW-1:0]                   opnd_ff, opnd_in;
   logic                            neg_ff, neg_in;

   // Pending and registered response
   logic                            pend_taken_ff, pend_taken_in;
   logic [smeu_pkg::LABEL_W-1:0]    pend_label_ff, pend_label_in;
   logic                            pend_pvalid_ff, pend_pvalid_in;
   logic [DW-1:0]                   pend_pvalue_ff, pend_pvalue_in;
   smeu_pkg::status_type            pend_status_ff, pend_status_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_taken_ff, rsp_taken_in;
   logic [smeu_pkg::LABEL_W-1:0]    rsp_label_ff, rsp_label_in;
   logic                            rsp_pvalid_ff, rsp_pvalid_in;
   logic [DW-1:0]                   rsp_pvalue_ff, rsp_pvalue_in;
   smeu_pkg::status_type            rsp_status_ff, rsp_status_in;

   // Memories and their registered read data
   logic [DW-1:0]                   stack_mem_ff [smeu_pkg::STACK_DEPTH];
   logic [DW-1:0]                   var_mem_ff [smeu_pkg::VAR_COUNT];
   logic [smeu_pkg::VAR_COUNT-1:0]  var_vld_ff;
   logic [DW-1:0]                   top_rd_ff, nxt_rd_ff, var_rd_ff;
   logic                            var_hit_ff;

   logic                            st_we, var_we;
   logic [smeu_pkg::ADDR_W-1:0]     st_waddr;
   logic [DW-1:0]                   st_wdata, var_wdata;

   logic                            req_fire;
   logic [smeu_pkg::SP_W-1:0]       sp_m1, sp_m2, sp_p1;
   logic                            under1, under2, full;
   logic [DW-1:0]                   var_val, top_abs, nxt_abs;

   logic [AW-1:0]                   alu_a, alu_b, alu_sum;
   logic                            alu_sub;

   logic [PW-1:0]                   prod_s;
   logic [QW:0]                     quot_s;
   logic                            fix_fits;
   logic [DW-1:0]                   fix_val, add_val;
   logic                            add_sat;
   logic [DW-1:0]                   max_val, min_val;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   assign sp_m1  = sp_ff - smeu_pkg::SP_W'(1);
   assign sp_m2  = sp_ff - smeu_pkg::SP_W'(2);
   assign sp_p1  = sp_ff + smeu_pkg::SP_W'(1);
   assign under1 = (sp_ff == '0);
   assign under2 = (sp_ff < smeu_pkg::SP_W'(2));
   assign full   = (sp_ff >= smeu_pkg::SP_W'(smeu_pkg::STACK_DEPTH));

   assign max_val = {1'b0, {(DW-1){1'b1}}};
   assign min_val = {1'b1, {(DW-1){1'b0}}};

   // Unwritten variable slots read as zero
   assign var_val = var_hit_ff ? var_rd_ff : '0;
   assign top_abs = top_rd_ff[DW-1] ? (~top_rd_ff + DW'(1)) : top_rd_ff;
   assign nxt_abs = nxt_rd_ff[DW-1] ? (~nxt_rd_ff + DW'(1)) : nxt_rd_ff;

   // Route operands into the shared add/subtract unit
   always_comb begin
      alu_a   = {{2{top_rd_ff[DW-1]}}, top_rd_ff};
      alu_b   = {{2{nxt_rd_ff[DW-1]}}, nxt_rd_ff};
      alu_sub = (op_ff != smeu_pkg::OP_ADD);
      unique case (state_ff)
         S_MUL: begin
            alu_a   = {2'b00, prod_ff[PW-1:DW]};
            alu_b   = prod_ff[0] ? {2'b00, opnd_ff} : '0;
            alu_sub = 1'b0;
         end
         S_DIV: begin
            alu_a   = {1'b0, rem_ff, dvd_ff[QW-1]};
            alu_b   = {2'b00, opnd_ff};
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

   // Saturate the add/sub result from 33 to 32 bits
   assign add_sat = (alu_sum[DW] != alu_sum[DW-1]);
   assign add_val = add_sat ? (alu_sum[AW-1] ? min_val : max_val) : alu_sum[DW-1:0];

   // Apply the sign to the magnitude result and saturate
   assign prod_s = neg_ff ? (~prod_ff + PW'(1)) : prod_ff;
   assign quot_s = neg_ff ? (~{1'b0, dvd_ff} + (QW+1)'(1)) : {1'b0, dvd_ff};

   always_comb begin
      if (op_ff == smeu_pkg::OP_MUL) begin
         fix_fits = (&prod_s[PW-1:DW+FRAC_POS-1]) || !(|prod_s[PW-1:DW+FRAC_POS-1]);
         fix_val  = fix_fits ? prod_s[DW+FRAC_POS-1:FRAC_POS]
                             : (prod_s[PW-1] ? min_val : max_val);
      end else begin
         fix_fits = (&quot_s[QW:DW-1]) || !(|quot_s[QW:DW-1]);
         fix_val  = fix_fits ? quot_s[DW-1:0] : (quot_s[QW] ? min_val : max_val);
      end
   end

   // Sequencer: next state, stack pointer, memory writes and response
   always_comb begin
      state_in       = state_ff;
      sp_in          = sp_ff;
      op_in          = op_ff;
      slot_in        = slot_ff;
      imm_in         = imm_ff;
      label_in       = label_ff;
      cnt_in         = cnt_ff;
      prod_in        = prod_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      opnd_in        = opnd_ff;
      neg_in         = neg_ff;
      pend_taken_in  = pend_taken_ff;
      pend_label_in  = pend_label_ff;
      pend_pvalid_in = pend_pvalid_ff;
      pend_pvalue_in = pend_pvalue_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_taken_in   = rsp_taken_ff;
      rsp_label_in   = rsp_label_ff;
      rsp_pvalid_in  = rsp_pvalid_ff;
      rsp_pvalue_in  = rsp_pvalue_ff;
      rsp_status_in  = rsp_status_ff;
      st_we          = 1'b0;
      st_waddr       = sp_ff[smeu_pkg::ADDR_W-1:0];
      st_wdata       = imm_ff;
      var_we         = 1'b0;
      var_wdata      = imm_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = smeu_pkg::op_type'(req_action);
               slot_in  = req_var_index[smeu_pkg::VAR_AW-1:0];
               imm_in   = req_immediate;
               label_in = req_label_id;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            pend_taken_in  = 1'b0;
            pend_label_in  = '0;
            pend_pvalid_in = 1'b0;
            pend_pvalue_in = '0;
            pend_status_in = smeu_pkg::ST_OK;
            state_in       = S_RESP;
            unique case (op_ff)
               smeu_pkg::OP_DATA: begin
                  var_we    = 1'b1;
                  var_wdata = imm_ff;
               end
               smeu_pkg::OP_ADD, smeu_pkg::OP_SUB: begin
                  if (under2) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else begin
                     st_we    = 1'b1;
                     st_waddr = sp_m2[smeu_pkg::ADDR_W-1:0];
                     st_wdata = add_val;
                     sp_in    = sp_m1;
                     if (add_sat) begin
                        pend_status_in = smeu_pkg::ST_SAT;
                     end
                  end
               end
               smeu_pkg::OP_MUL: begin
                  if (under2) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else begin
                     prod_in  = {{DW{1'b0}}, nxt_abs};
                     opnd_in  = top_abs;
                     neg_in   = top_rd_ff[DW-1] ^ nxt_rd_ff[DW-1];
                     cnt_in   = '0;
                     state_in = S_MUL;
                  end
               end
               smeu_pkg::OP_DIV: begin
                  if (under2) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else if (nxt_rd_ff == '0) begin
                     pend_status_in = smeu_pkg::ST_DIVZ;
                  end else begin
                     dvd_in   = {top_abs, {FRAC_POS{1'b0}}};
                     rem_in   = '0;
                     opnd_in  = nxt_abs;
                     neg_in   = top_rd_ff[DW-1] ^ nxt_rd_ff[DW-1];
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end
               smeu_pkg::OP_LOAD: begin
                  if (full) begin
                     pend_status_in = smeu_pkg::ST_OVER;
                  end else begin
                     st_we    = 1'b1;
                     st_wdata = var_val;
                     sp_in    = sp_p1;
                  end
               end
               smeu_pkg::OP_STORE: begin
                  if (under1) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else begin
                     var_we    = 1'b1;
                     var_wdata = top_rd_ff;
                     sp_in     = sp_m1;
                  end
               end
               smeu_pkg::OP_DUP: begin
                  if (under1) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else if (full) begin
                     pend_status_in = smeu_pkg::ST_OVER;
                  end else begin
                     st_we    = 1'b1;
                     st_wdata = top_rd_ff;
                     sp_in    = sp_p1;
                  end
               end
               smeu_pkg::OP_PUSH: begin
                  if (full) begin
                     pend_status_in = smeu_pkg::ST_OVER;
                  end else begin
                     st_we    = 1'b1;
                     st_wdata = imm_ff;
                     sp_in    = sp_p1;
                  end
               end
               smeu_pkg::OP_SWAP: begin
                  if (under2) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else begin
                     st_we    = 1'b1;
                     st_waddr = sp_m1[smeu_pkg::ADDR_W-1:0];
                     st_wdata = nxt_rd_ff;
                     state_in = S_SWAP;
                  end
               end
               smeu_pkg::OP_JNE, smeu_pkg::OP_JG: begin
                  if (under2) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else begin
                     sp_in = sp_m2;
                     if ((alu_sum != '0) &&
                         ((op_ff == smeu_pkg::OP_JNE) || !alu_sum[AW-1])) begin
                        pend_taken_in = 1'b1;
                        pend_label_in = label_ff;
                     end
                  end
               end
               smeu_pkg::OP_JMP: begin
                  pend_taken_in = 1'b1;
                  pend_label_in = label_ff;
               end
               smeu_pkg::OP_PRINT: begin
                  if (under1) begin
                     pend_status_in = smeu_pkg::ST_UNDER;
                  end else begin
                     pend_pvalid_in = 1'b1;
                     pend_pvalue_in = top_rd_ff;
                     sp_in          = sp_m1;
                  end
               end
               default: begin
               end
            endcase
         end

         S_MUL: begin
            prod_in = {alu_sum[DW:0], prod_ff[DW-1:1]};
            cnt_in  = cnt_ff + smeu_pkg::CNT_W'(1);
            if (cnt_ff == smeu_pkg::CNT_W'(smeu_pkg::MUL_STEPS - 1)) begin
               state_in = S_FIX;
            end
         end

         S_DIV: begin
            rem_in = alu_sum[AW-1] ? alu_a[DW-1:0] : alu_sum[DW-1:0];
            dvd_in = {dvd_ff[QW-2:0], !alu_sum[AW-1]};
            cnt_in = cnt_ff + smeu_pkg::CNT_W'(1);
            if (cnt_ff == smeu_pkg::CNT_W'(smeu_pkg::DIV_STEPS - 1)) begin
               state_in = S_FIX;
            end
         end

         S_FIX: begin
            st_we          = 1'b1;
            st_waddr       = sp_m2[smeu_pkg::ADDR_W-1:0];
            st_wdata       = fix_val;
            sp_in          = sp_m1;
            pend_status_in = fix_fits ? smeu_pkg::ST_OK : smeu_pkg::ST_SAT;
            state_in       = S_RESP;
         end

         S_SWAP: begin
            st_we    = 1'b1;
            st_waddr = sp_m2[smeu_pkg::ADDR_W-1:0];
            st_wdata = top_rd_ff;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_taken_in  = pend_taken_ff;
               rsp_label_in  = pend_label_ff;
               rsp_pvalid_in = pend_pvalid_ff;
               rsp_pvalue_in = pend_pvalue_ff;
               rsp_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, stack pointer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      slot_ff        <= slot_in;
      imm_ff         <= imm_in;
      label_ff       <= label_in;
      cnt_ff         <= cnt_in;
      prod_ff        <= prod_in;
      rem_ff         <= rem_in;
      dvd_ff         <= dvd_in;
      opnd_ff        <= opnd_in;
      neg_ff         <= neg_in;
      pend_taken_ff  <= pend_taken_in;
      pend_label_ff  <= pend_label_in;
      pend_pvalid_ff <= pend_pvalid_in;
      pend_pvalue_ff <= pend_pvalue_in;
      pend_status_ff <= pend_status_in;
      rsp_taken_ff   <= rsp_taken_in;
      rsp_label_ff   <= rsp_label_in;
      rsp_pvalid_ff  <= rsp_pvalid_in;
      rsp_pvalue_ff  <= rsp_pvalue_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Operand stack: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_mem_ff[st_waddr] <= st_wdata;
      end
      if (req_fire) begin
         top_rd_ff <= stack_mem_ff[sp_m1[smeu_pkg::ADDR_W-1:0]];
         nxt_rd_ff <= stack_mem_ff[sp_m2[smeu_pkg::ADDR_W-1:0]];
      end
   end

   // Variable store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (var_we) begin
         var_mem_ff[slot_ff] <= var_wdata;
      end
      if (req_fire) begin
         var_rd_ff <= var_mem_ff[req_var_index[smeu_pkg::VAR_AW-1:0]];
      end
   end

   // Mark written slots; reset clears every mark at once
   always_ff @(posedge clock) begin
      if (reset) begin
         var_vld_ff <= '0;
      end else if (var_we) begin
         var_vld_ff[slot_ff] <= 1'b1;
      end
      if (req_fire) begin
         var_hit_ff <= var_vld_ff[req_var_index[smeu_pkg::VAR_AW-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_branch_taken = rsp_taken_ff;
   assign rsp_branch_label = rsp_label_ff;
   assign rsp_print_valid  = rsp_pvalid_ff;
   assign rsp_print_value  = rsp_pvalue_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/smeu_checker.sv =====
// ----------------------------------------------------------------------------
// smeu_checker
// Port-level checks on the request handshake and the response words of the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module smeu_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic                               rsp_branch_taken,
   input wire logic [smeu_pkg::LABEL_W-1:0]       rsp_branch_label,
   input wire logic                               rsp_print_valid,
   input wire logic signed [smeu_pkg::DATA_W-1:0] rsp_print_value,
   input wire logic [smeu_pkg::STATUS_W-1:0]      rsp_status
);

   // Hold a stalled response word
   `SMEU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Drive the label only with a branch request
   `SMEU_ASSERT_NOW(a_label_zero, clock, reset, rsp_valid && !rsp_branch_taken, rsp_branch_label == '0)

   // Drive the printed value only with a print
   `SMEU_ASSERT_NOW(a_print_zero, clock, reset, rsp_valid && !rsp_print_valid, rsp_print_value == '0)

   // A faulting instruction requests no branch and prints nothing
   `SMEU_ASSERT_NOW(a_fault_quiet, clock, reset, rsp_valid && (rsp_status == smeu_pkg::ST_UNDER || rsp_status == smeu_pkg::ST_OVER || rsp_status == smeu_pkg::ST_DIVZ), !rsp_branch_taken && !rsp_print_valid)

   // Never accept a request while a word is being worked on after acceptance
   `SMEU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_branch_taken (rsp_branch_taken),
   .rsp_branch_label (rsp_branch_label),
   .rsp_print_valid  (rsp_print_valid),
   .rsp_print_value  (rsp_print_value),
   .rsp_status       (rsp_status)
);

`default_nettype wire
